// ===== rtl/bdhc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the button debounce and hold classifier.
// No dependencies; every other file of the block imports this package.
package bdhc_pkg;

  // Field widths fixed by the item formats
  localparam int NOW_W    = 32;
  localparam int DEB_W    = 16;
  localparam int HOLD_W   = 32;
  localparam int EVENT_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SHORT   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_PAIRING = 2'd2;
  localparam logic [EVENT_W-1:0] EV_RESET   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIRING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd50;
  localparam logic [HOLD_W-1:0] PAIRING_RST  = 32'd3000;
  localparam logic [HOLD_W-1:0] RESET_RST    = 32'd10000;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_time;
    logic [HOLD_W-1:0] pairing_hold_time;
    logic [HOLD_W-1:0] reset_hold_time;
  } cfg_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic               is_down;
  } result_t;

endpackage

// ===== rtl/bdhc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the classifier: one pin poll per item.
// Depends on bdhc_pkg for field widths.
interface bdhc_in_if;
  import bdhc_pkg::*;

  logic             valid;
  logic             ready;
  logic             pin_level;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

// ===== rtl/bdhc_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the classifier: one event and debounced state per item.
// Depends on bdhc_pkg for field widths.
interface bdhc_out_if;
  import bdhc_pkg::*;

  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic               is_down;

  modport source (output valid, output event_res, output is_down, input ready);
  modport sink   (input valid, input event_res, input is_down, output ready);
endinterface

// ===== rtl/bdhc_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers of the classifier: debounce and hold thresholds.
// Depends on bdhc_pkg for the register indexes and the cfg_t bundle.
module bdhc_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bdhc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bdhc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output bdhc_pkg::cfg_t                        cfg
);
  import bdhc_pkg::*;

  cfg_t cfg_r;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time     <= DEBOUNCE_RST;
      cfg_r.pairing_hold_time <= PAIRING_RST;
      cfg_r.reset_hold_time   <= RESET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce_time     <= cfg_wdata[DEB_W-1:0];
        CFG_PAIRING:  cfg_r.pairing_hold_time <= cfg_wdata[HOLD_W-1:0];
        CFG_RESET:    cfg_r.reset_hold_time   <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bdhc_core.sv =====
`timescale 1ns / 1ps
// Input register, debounce/hold state and classification logic.
// Depends on bdhc_pkg; feeds one result per item to the output stage.
module bdhc_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bdhc_pkg::cfg_t            cfg,
  // input side
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_pin_level,
  input  logic [bdhc_pkg::NOW_W-1:0] in_now_ms,
  // result side
  output logic                      res_valid,
  input  logic                      res_ready,
  output bdhc_pkg::result_t         res
);
  import bdhc_pkg::*;

  // Compare width: wide enough for both the time differences and the thresholds
  localparam int CW = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;
  localparam int NW = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

  logic                 s1_valid_r;
  logic                 s1_pin_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic [NW-1:0]        now_ext;
  logic                 advance;

  logic                 stable_r, stable_nxt;
  logic                 last_raw_r, last_raw_nxt;
  logic [TIME_BITS-1:0] raw_change_r, raw_change_nxt;
  logic [TIME_BITS-1:0] press_start_r, press_start_nxt;
  logic                 rst_done_r, rst_done_nxt;
  logic                 pair_done_r, pair_done_nxt;

  logic                 raw;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] held;
  logic                 settled;
  logic                 reset_hit;
  logic                 pair_hit;
  logic [EVENT_W-1:0]   ev;

  assign advance   = s1_valid_r && res_ready;
  assign in_ready  = !s1_valid_r || res_ready;
  assign res_valid = s1_valid_r;
  assign now_ext   = NW'(in_now_ms);

  // Hold the polled item in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pin_r <= in_pin_level;
      s1_now_r <= now_ext[TIME_BITS-1:0];
    end
  end

  // Wrapped time differences and threshold compares
  assign raw          = ~s1_pin_r;
  assign since_change = s1_now_r - raw_change_r;
  assign held         = s1_now_r - press_start_r;
  assign settled      = CW'(since_change) >= CW'(cfg.debounce_time);
  assign reset_hit    = CW'(held) >= CW'(cfg.reset_hold_time);
  assign pair_hit     = CW'(held) >= CW'(cfg.pairing_hold_time);

  // Classify the poll and work out the next state
  always_comb begin
    stable_nxt      = stable_r;
    last_raw_nxt    = last_raw_r;
    raw_change_nxt  = raw_change_r;
    press_start_nxt = press_start_r;
    rst_done_nxt    = rst_done_r;
    pair_done_nxt   = pair_done_r;
    ev              = EV_NONE;
    if (raw != last_raw_r) begin
      last_raw_nxt   = raw;
      raw_change_nxt = s1_now_r;
    end else if (settled) begin
      if (raw == stable_r) begin
        if (stable_r) begin
          if (!rst_done_r && reset_hit) begin
            rst_done_nxt = 1'b1;
            ev           = EV_RESET;
          end else if (!pair_done_r && pair_hit) begin
            pair_done_nxt = 1'b1;
            ev            = EV_PAIRING;
          end
        end
      end else begin
        stable_nxt = raw;
        if (raw) begin
          press_start_nxt = s1_now_r;
          rst_done_nxt    = 1'b0;
          pair_done_nxt   = 1'b0;
        end else if (!pair_done_r && !rst_done_r && !pair_hit) begin
          ev = EV_SHORT;
        end
      end
    end
  end

  // Advance the state as the item moves on to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= 1'b0;
      last_raw_r    <= 1'b0;
      raw_change_r  <= '0;
      press_start_r <= '0;
      rst_done_r    <= 1'b0;
      pair_done_r   <= 1'b0;
    end else if (advance) begin
      stable_r      <= stable_nxt;
      last_raw_r    <= last_raw_nxt;
      raw_change_r  <= raw_change_nxt;
      press_start_r <= press_start_nxt;
      rst_done_r    <= rst_done_nxt;
      pair_done_r   <= pair_done_nxt;
    end
  end

  assign res.event_res = ev;
  assign res.is_down   = stable_nxt;

endmodule

// ===== rtl/bdhc_out_reg.sv =====
`timescale 1ns / 1ps
// Result register of the classifier: holds one item until the receiver takes it.
// Depends on bdhc_pkg for result_t and bdhc_out_if for the channel.
module bdhc_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  output logic               res_ready,
  input  bdhc_pkg::result_t  res,
  bdhc_out_if.source         out_ch
);
  import bdhc_pkg::*;

  logic    valid_r;
  result_t data_r;

  // Take a new item when empty or when the held one leaves this cycle
  assign res_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.event_res = data_r.event_res;
  assign out_ch.is_down   = data_r.is_down;

endmodule

// ===== rtl/button_debounce_hold_classifier.sv =====
`timescale 1ns / 1ps
// Button debounce and hold classifier, top level.
// Each input item is one poll: the raw active-low pin level and the current
// millisecond time. Each poll gives exactly one result item: an event code
// (none, short press, pairing hold, reset hold) and the debounced state.
// Channels: in_ch (valid/ready, pin_level, now_ms) and out_ch (valid/ready,
// event_res, is_down); an item moves when valid and ready are both high.
// cfg_we/cfg_index/cfg_wdata write the debounce, pairing and reset thresholds;
// write them only while no item is in flight.
// An accepted poll moves through the input register, then the result register,
// before its result is offered on out_ch.
// Throughput: one item per cycle while out_ch.ready stays high, set by the
// single pass of compares between the input register and the result register.
// Reset (rst_n low, synchronous) empties both registers, clears the debounce
// state and loads the thresholds 50, 3000 and 10000 ms.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more poll before in_ch.ready drops.
// TIME_BITS sets the width of the stored times and of the wrapped differences.
// Depends on bdhc_pkg, bdhc_in_if, bdhc_out_if, bdhc_cfg, bdhc_core, bdhc_out_reg.
module button_debounce_hold_classifier #(
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bdhc_in_if.sink                            in_ch,
  bdhc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [bdhc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdhc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bdhc_pkg::*;

  cfg_t    cfg;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  bdhc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdhc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_pin_level (in_ch.pin_level),
    .in_now_ms    (in_ch.now_ms),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  bdhc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule
